/* sv/pfm_pkg.sv */
package pfm_pkg;

	// Field and register widths.
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned UNIT_W   = 12;
	localparam int unsigned KEEP_W   = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned RATE_W   = 32;

	// Scale factor from seconds to milliseconds.
	localparam int unsigned RATE_SCALE = 1000;
	localparam int unsigned SCALE_W    = 10;

	// Scaled unit (unit * 1000) and full numerator widths.
	localparam int unsigned MPLIER_W = UNIT_W + SCALE_W;
	localparam int unsigned NUM_W    = MPLIER_W + COUNT_W;

	// Serial step counts: one multiplier bit, then one quotient bit, per cycle.
	localparam int unsigned MUL_STEPS = MPLIER_W;
	localparam int unsigned DIV_STEPS = NUM_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SECONDS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEPOUT_MS   = 1'b1;

	// Item opcodes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	// Reset values.
	localparam logic [UNIT_W-1:0] UNIT_RESET    = 12'd1;
	localparam logic [KEEP_W-1:0] KEEPOUT_RESET = 16'd10;
	localparam logic              LEVEL_RESET   = 1'b1;

endpackage

/* sv/pulse_frequency_meter.sv */
// Channel   Direction  Signals                                       Handshake
// -------   ---------  --------------------------------------------  ---------------
// in        input      opcode, now_ms, pin_level, report_taken       in_valid/in_ready
// out       output     rate                                          out_valid/out_ready
// cfg       input      cfg_idx, cfg_data                             cfg_we, no wait
//
// A pin sample, or a report without enough data, is done in the cycle it is accepted.
// A report with enough data loads its word into the output register after the serial math
// (22 multiplier steps, 54 divider steps, then the load once the output register is free).
// Input is refused from the acceptance of such a report until its word is loaded; a word
// still waiting in the output register stalls the block only at the end of the next report.
// Reset is asynchronous and gives the count zero, both edge times zero and the level high.
module pulse_frequency_meter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pfm_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [pfm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [pfm_pkg::TIME_W-1:0]        now_ms,
	input  logic                              pin_level,
	input  logic                              report_taken,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pfm_pkg::RATE_W-1:0]        rate
);

	localparam int unsigned MPLIER_W = pfm_pkg::MPLIER_W;
	localparam int unsigned NUM_W    = pfm_pkg::NUM_W;
	localparam int unsigned COUNT_W  = pfm_pkg::COUNT_W;
	localparam int unsigned TIME_W   = pfm_pkg::TIME_W;
	localparam int unsigned RATE_W   = pfm_pkg::RATE_W;
	localparam int unsigned STEP_W   = pfm_pkg::STEP_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [pfm_pkg::UNIT_W-1:0] unit_q;
	logic [pfm_pkg::KEEP_W-1:0] keepout_q;

	// Edge tracking state.
	logic                 level_q;
	logic [COUNT_W-1:0]   count_q;
	logic [TIME_W-1:0]    first_q;
	logic [TIME_W-1:0]    last_q;

	// Serial arithmetic registers.
	logic [NUM_W-1:0]     work_q;
	logic [COUNT_W-1:0]   mcand_q;
	logic [TIME_W-1:0]    span_q;
	logic [TIME_W-1:0]    rem_q;
	logic [RATE_W-1:0]    quot_q;
	logic                 sticky_q;
	logic [STEP_W-1:0]    step_q;

	// Output register.
	logic                 out_valid_q;
	logic [RATE_W-1:0]    rate_q;

	logic                 in_fire;
	logic [TIME_W-1:0]    since_last;
	logic                 sample_edge;
	logic [TIME_W-1:0]    span_now;
	logic                 report_ok;
	logic [MPLIER_W-1:0]  scaled_unit;
	logic [COUNT_W:0]     mul_sum;
	logic [TIME_W:0]      div_trial;
	logic [TIME_W:0]      div_diff;
	logic                 div_ge;
	logic                 out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign rate      = rate_q;
	assign out_free  = !out_valid_q || out_ready;

	// Sample path: keepout test on the wrapping time since the last counted edge.
	assign since_last  = now_ms - last_q;
	assign sample_edge = (since_last > TIME_W'(keepout_q)) && (pin_level != level_q);

	// Report path: enough data means count_q is above one and the span is nonzero.
	assign span_now    = last_q - first_q;
	assign report_ok   = (count_q > COUNT_W'(1)) && (span_now != '0);
	assign scaled_unit = MPLIER_W'(unit_q) * MPLIER_W'(pfm_pkg::RATE_SCALE);

	// Shift-add multiplier step: add the count when the low multiplier bit is set.
	assign mul_sum = {1'b0, work_q[NUM_W-1:MPLIER_W]}
		+ (work_q[0] ? {1'b0, mcand_q} : '0);

	// Restoring divider step: bring in the next numerator bit and try the subtract.
	// The remainder stays below the span, so a borrow out of the top bit means too small.
	assign div_trial = {rem_q, work_q[NUM_W-1]};
	assign div_diff  = div_trial - {1'b0, span_q};
	assign div_ge    = !div_diff[TIME_W];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q    <= pfm_pkg::UNIT_RESET;
			keepout_q <= pfm_pkg::KEEPOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pfm_pkg::CFG_UNIT_SECONDS: unit_q    <= cfg_data[pfm_pkg::UNIT_W-1:0];
				pfm_pkg::CFG_KEEPOUT_MS:   keepout_q <= cfg_data[pfm_pkg::KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Edge tracking and the report sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			level_q     <= pfm_pkg::LEVEL_RESET;
			count_q     <= '0;
			first_q     <= '0;
			last_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output word stays until it is taken; a finished report loads a new one.
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && opcode == pfm_pkg::OP_SAMPLE && sample_edge) begin
						level_q <= pin_level;
						if (pin_level) begin
							last_q <= now_ms;
							if (count_q == '0) begin
								first_q <= now_ms;
							end
							if (count_q != '1) begin
								count_q <= count_q + COUNT_W'(1);
							end
						end
					end else if (in_fire && opcode == pfm_pkg::OP_REPORT && report_ok) begin
						if (report_taken) begin
							count_q <= '0;
						end
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (step_q == STEP_W'(pfm_pkg::MUL_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= S_DIV;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_DIV: begin
					if (step_q == STEP_W'(pfm_pkg::DIV_STEPS - 1)) begin
						state_q <= S_OUT;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath of the serial multiplier and divider, and the output word.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				work_q   <= {{COUNT_W{1'b0}}, scaled_unit};
				mcand_q  <= count_q;
				span_q   <= span_now;
				rem_q    <= '0;
				quot_q   <= '0;
				sticky_q <= 1'b0;
			end
			S_MUL: begin
				work_q <= {mul_sum, work_q[MPLIER_W-1:1]};
			end
			S_DIV: begin
				work_q   <= {work_q[NUM_W-2:0], 1'b0};
				rem_q    <= div_ge ? div_diff[TIME_W-1:0] : div_trial[TIME_W-1:0];
				quot_q   <= {quot_q[RATE_W-2:0], div_ge};
				sticky_q <= sticky_q | quot_q[RATE_W-1];
			end
			S_OUT: begin
				if (out_free) begin
					rate_q <= sticky_q ? '1 : quot_q;
				end
			end
			default: ;
		endcase
	end

endmodule
